[hdl/delta_list_timer_queue_assert.svh]
// Assertion macros for the delta list timer queue checker.
`ifndef DELTA_LIST_TIMER_QUEUE_ASSERT_SVH
`define DELTA_LIST_TIMER_QUEUE_ASSERT_SVH
// Implication checked on every clock, quiet during reset.
`define DLTQ_ASSERT_IMPL(label, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define DLTQ_ASSERT_NEXT(label, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[hdl/dltq_pkg.sv]
// Package: types, codes and constants for the delta list timer queue.
`default_nettype none
package dltq_pkg;
  localparam int unsigned TimerSlots = 16;
  localparam int unsigned SlotW = $clog2(TimerSlots);
  localparam int unsigned CountW = $clog2(TimerSlots + 1);
  localparam int unsigned DeltaW = 32;
  localparam int unsigned PeriodW = 10;
  localparam int unsigned IndexW = 4;
  localparam int unsigned FlagCount = 16;
  localparam int unsigned DivCntW = 6;

  typedef enum logic [1:0] {
    FUNC_SET   = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_CHECK = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_FULLCHK,
    ST_SEARCH,
    ST_SHIFT,
    ST_PLACE,
    ST_FIX,
    ST_TICK_DEC,
    ST_TICK_POP,
    ST_POP_SHIFT,
    ST_CHECK,
    ST_DONE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_item;
    logic div_start;
    logic div_step;
    logic search_init;
    logic search_step;
    logic shift_init;
    logic shift_step;
    logic place;
    logic fix_next;
    logic head_dec;
    logic pop_flag;
    logic pop_init;
    logic pop_step;
    logic pop_done;
    logic check_flag;
    logic set_accept;
    logic clear_result;
    logic out_load;
  } dltq_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic div_done;
    logic list_full;
    logic list_empty;
    logic search_stop;
    logic shift_done;
    logic has_next;
    logic head_zero;
    logic pop_shift_done;
  } dltq_stat_t;
endpackage
`default_nettype wire

[hdl/dltq_ctrl.sv]
// Controller state machine for the delta list timer queue.
`default_nettype none
module dltq_ctrl
  import dltq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_fire,
  input  wire func_t      func,
  input  wire logic       out_busy,
  input  wire dltq_stat_t stat,
  output logic            busy,
  output dltq_cmd_t       cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (func)
            FUNC_SET:   state_next = ST_DIV;
            FUNC_TICK:  state_next = ST_TICK_DEC;
            FUNC_CHECK: state_next = ST_CHECK;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_DIV:       if (stat.div_done) state_next = ST_FULLCHK;
      ST_FULLCHK:   state_next = stat.list_full ? ST_DONE : ST_SEARCH;
      ST_SEARCH:    if (stat.search_stop) state_next = ST_SHIFT;
      ST_SHIFT:     if (stat.shift_done) state_next = ST_PLACE;
      ST_PLACE:     state_next = stat.has_next ? ST_FIX : ST_DONE;
      ST_FIX:       state_next = ST_DONE;
      ST_TICK_DEC:  state_next = stat.list_empty ? ST_DONE : ST_TICK_POP;
      ST_TICK_POP:  state_next = (!stat.list_empty && stat.head_zero) ? ST_POP_SHIFT
                                                                       : ST_DONE;
      ST_POP_SHIFT: if (stat.pop_shift_done) state_next = ST_TICK_POP;
      ST_CHECK:     state_next = ST_DONE;
      ST_DONE:      if (!out_busy) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.load_item    = in_fire;
        cmd.clear_result = in_fire;
        cmd.div_start    = in_fire && (func == FUNC_SET);
      end
      ST_DIV:     cmd.div_step = 1'b1;
      ST_FULLCHK: cmd.search_init = !stat.list_full;
      ST_SEARCH: begin
        cmd.search_step = !stat.search_stop;
        cmd.shift_init  = stat.search_stop;
      end
      ST_SHIFT:  cmd.shift_step = !stat.shift_done;
      ST_PLACE: begin
        cmd.place      = 1'b1;
        cmd.set_accept = 1'b1;
      end
      ST_FIX:      cmd.fix_next = 1'b1;
      ST_TICK_DEC: cmd.head_dec = !stat.list_empty;
      ST_TICK_POP: begin
        cmd.pop_flag = !stat.list_empty && stat.head_zero;
        cmd.pop_init = !stat.list_empty && stat.head_zero;
      end
      ST_POP_SHIFT: begin
        cmd.pop_step = !stat.pop_shift_done;
        cmd.pop_done = stat.pop_shift_done;
      end
      ST_CHECK: cmd.check_flag = 1'b1;
      ST_DONE:  cmd.out_load = !out_busy;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[hdl/dltq_datapath.sv]
// Datapath: divider, entry memories, list length and expiry flags.
`default_nettype none
module dltq_datapath
  import dltq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dltq_cmd_t           cmd,
  input  wire logic [PeriodW-1:0]  period,
  input  wire logic [IndexW-1:0]   timer_index,
  input  wire logic [DeltaW-1:0]   duration_ms,
  output dltq_stat_t               stat,
  output logic                     res_flag,
  output logic                     res_acc,
  output logic [CountW-1:0]        res_expired,
  output logic [CountW-1:0]        res_pending
);
  logic [IndexW-1:0]  ent_timer [TimerSlots];
  logic [DeltaW-1:0]  ent_delta [TimerSlots];
  logic [FlagCount-1:0] flags;
  logic [CountW-1:0]  len;
  logic [IndexW-1:0]  idx;
  // Restoring divider
  logic [DeltaW-1:0]  quo;
  logic [PeriodW-1:0] rem;
  logic [PeriodW-1:0] dvs;
  logic [DivCntW-1:0] dcnt;
  logic [PeriodW:0]   rem_sh;
  logic [PeriodW:0]   rem_sub;
  // Search
  logic [DeltaW:0]    prior_sum;
  logic [DeltaW:0]    total;
  logic [CountW-1:0]  pos;
  logic [CountW-1:0]  k;
  logic [DeltaW-1:0]  own;
  logic [SlotW-1:0]   pos_s;
  logic [SlotW-1:0]   k_s;
  logic [SlotW-1:0]   km1_s;
  logic [SlotW-1:0]   kp1_s;
  logic [SlotW-1:0]   posp1_s;

  assign pos_s   = pos[SlotW-1:0];
  assign k_s     = k[SlotW-1:0];
  assign km1_s   = k_s - SlotW'(1);
  assign kp1_s   = k_s + SlotW'(1);
  assign posp1_s = pos_s + SlotW'(1);
  assign total   = prior_sum + {1'b0, ent_delta[pos_s]};
  assign rem_sh  = {rem, quo[DeltaW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign own     = quo - prior_sum[DeltaW-1:0];

  assign stat.div_done       = (dcnt == '0);
  assign stat.list_full      = (len == CountW'(TimerSlots));
  assign stat.list_empty     = (len == '0);
  assign stat.search_stop    = (pos == len) || ({1'b0, quo} < total);
  assign stat.shift_done     = (k == pos);
  assign stat.has_next       = (pos < len);
  assign stat.head_zero      = (ent_delta[0] == '0);
  assign stat.pop_shift_done = (CountW'(k + CountW'(1)) >= len);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      idx <= timer_index;
      quo <= duration_ms;
      rem <= '0;
      dvs <= (period == '0) ? PeriodW'(1) : period;
    end
    if (cmd.div_start) dcnt <= DivCntW'(DeltaW);
    if (cmd.div_step && dcnt != '0) begin
      dcnt <= dcnt - DivCntW'(1);
      if (!rem_sub[PeriodW]) begin
        rem <= rem_sub[PeriodW-1:0];
        quo <= {quo[DeltaW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[PeriodW-1:0];
        quo <= {quo[DeltaW-2:0], 1'b0};
      end
    end
    if (cmd.search_init) begin
      prior_sum <= '0;
      pos       <= '0;
    end
    if (cmd.search_step) begin
      prior_sum <= total;
      pos       <= pos + CountW'(1);
    end
    if (cmd.shift_init) k <= len;
    if (cmd.shift_step) begin
      ent_timer[k_s] <= ent_timer[km1_s];
      ent_delta[k_s] <= ent_delta[km1_s];
      k <= k - CountW'(1);
    end
    if (cmd.place) begin
      ent_timer[pos_s] <= idx;
      ent_delta[pos_s] <= own;
    end
    if (cmd.fix_next)
      ent_delta[posp1_s] <= ent_delta[posp1_s] - quo + prior_sum[DeltaW-1:0];
    if (cmd.head_dec && !stat.head_zero) ent_delta[0] <= ent_delta[0] - DeltaW'(1);
    if (cmd.pop_init) k <= '0;
    if (cmd.pop_step) begin
      ent_timer[k_s] <= ent_timer[kp1_s];
      ent_delta[k_s] <= ent_delta[kp1_s];
      k <= k + CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len         <= '0;
      flags       <= '0;
      res_flag    <= 1'b0;
      res_acc     <= 1'b0;
      res_expired <= '0;
    end else begin
      if (cmd.clear_result) begin
        res_flag    <= 1'b0;
        res_acc     <= 1'b0;
        res_expired <= '0;
      end
      if (cmd.set_accept) begin
        res_acc <= 1'b1;
        len     <= len + CountW'(1);
      end
      if (cmd.pop_flag) begin
        flags[ent_timer[0]] <= 1'b1;
        res_expired <= res_expired + CountW'(1);
      end
      if (cmd.pop_done) len <= len - CountW'(1);
      if (cmd.check_flag) begin
        res_flag   <= flags[idx];
        flags[idx] <= 1'b0;
      end
    end
  end

  assign res_pending = len;
endmodule
`default_nettype wire

[hdl/delta_list_timer_queue.sv]
// Top level: delta list one-shot timer queue with valid/ready channels.
// Flow: a set divides duration_ms by tick_period_ms, then searches, shifts and places
//   the entry and adjusts the next one if any; a set on a full list is refused; a tick
//   decrements the head, then pops each expired timer; set uses a 32-step divider.
// One transaction at a time; in_ready returns in the same cycle that out_valid rises.
// Reset: rst synchronous active high; empties the list, clears flags, tick_period_ms = 10.
`default_nettype none
module delta_list_timer_queue
  import dltq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [PeriodW-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        func,
  input  wire logic [IndexW-1:0] timer_index,
  input  wire logic [DeltaW-1:0] duration_ms,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   flag_value,
  output logic                   accepted,
  output logic [CountW-1:0]      expired_now,
  output logic [CountW-1:0]      pending_count
);
  logic [PeriodW-1:0] tick_period_ms;
  dltq_cmd_t  cmd;
  dltq_stat_t stat;
  logic busy;
  logic in_fire;
  logic out_busy;
  logic res_flag, res_acc;
  logic [CountW-1:0] res_expired, res_pending;

  // Config register; the user must write it only while idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst)         tick_period_ms <= PeriodW'(10);
    else if (cfg_we) tick_period_ms <= cfg_wdata;
  end

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  // Output register is free if empty or being drained this cycle.
  assign out_busy = out_valid && !out_ready;

  dltq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .func(func_t'(func)),
    .out_busy(out_busy), .stat(stat), .busy(busy), .cmd(cmd)
  );

  dltq_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .period(tick_period_ms),
    .timer_index(timer_index), .duration_ms(duration_ms), .stat(stat),
    .res_flag(res_flag), .res_acc(res_acc), .res_expired(res_expired),
    .res_pending(res_pending)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      flag_value    <= res_flag;
      accepted      <= res_acc;
      expired_now   <= res_expired;
      pending_count <= res_pending;
    end
  end
endmodule
`default_nettype wire

[hdl/dltq_checker.sv]
// Port-level checker for the delta list timer queue, bound to the top level.
`default_nettype none
`include "delta_list_timer_queue_assert.svh"
module dltq_checker
  import dltq_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              accepted,
  input wire logic              flag_value,
  input wire logic [CountW-1:0] expired_now,
  input wire logic [CountW-1:0] pending_count
);
  `DLTQ_ASSERT_NEXT(a_busy_after_accept, rst, in_valid && in_ready, !in_ready, "ready after accept")
  `DLTQ_ASSERT_IMPL(a_count_range, rst, out_valid, pending_count <= CountW'(TimerSlots), "count range")
  `DLTQ_ASSERT_IMPL(a_one_meaning, rst, out_valid, !(accepted && (flag_value || expired_now != '0)), "fields mixed")
  `DLTQ_ASSERT_NEXT(a_out_hold, rst, out_valid && !out_ready, out_valid && $stable(pending_count), "output dropped")
endmodule

bind delta_list_timer_queue dltq_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
  .flag_value(flag_value), .expired_now(expired_now), .pending_count(pending_count)
);
`default_nettype wire
